// ===== rtl/xmm_pkg.sv =====
// Shared types and constants for the XOR-masked MEX search block.
`default_nettype none
package xmm_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int VALUE_W        = 16;
  localparam int MEX_W          = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Control travelling with an item from one level cell to the next.
  typedef struct packed {
    logic vld;
    cmd_t cmd;
    logic done;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/xmm_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module xmm_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Read data holds its value until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/xmm_cell.sv =====
// One tree level: sibling count pairs for that level and the step decision for an item.
`default_nettype none
module xmm_cell
  import xmm_pkg::*;
#(
  parameter int VB    = VALUE_BITS_DEF,
  parameter int LEVEL = 1,
  parameter int CLR_W = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr_en,
  input  wire logic [CLR_W-1:0] clr_addr,
  input  wire logic          commit,
  input  wire ctl_t          req_i,
  input  wire logic [VB-1:0] path_i,
  input  wire logic [VB-1:0] mask_i,
  input  wire logic [VB-1:0] res_i,
  output ctl_t               req_o,
  output logic      [VB-1:0] path_o,
  output logic      [VB-1:0] mask_o,
  output logic      [VB-1:0] res_o
);

  localparam int AW  = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int CW  = VB - LEVEL + 1;
  localparam int BIT = VB - LEVEL;
  localparam bit IS_LEAF = (LEVEL == VB);
  localparam logic [CW-1:0] CAP = CW'(1 << BIT);

  ctl_t            ctl_r;
  logic [VB-1:0]   path_r;
  logic [VB-1:0]   mask_r;
  logic [VB-1:0]   res_r;
  logic [AW-1:0]   req_addr;
  logic [AW-1:0]   hold_addr;
  logic [AW-1:0]   clr_a;
  logic [AW-1:0]   ram_addr;
  logic [2*CW-1:0] ram_rdata;
  logic [2*CW-1:0] ram_wdata;
  logic [2*CW-1:0] inc_pair;
  logic [CW-1:0]   c0;
  logic [CW-1:0]   c1;
  logic [CW-1:0]   go_cnt;
  logic [CW-1:0]   alt_cnt;
  logic [CW-1:0]   sel_cnt;
  logic            b;

  generate
    if (LEVEL > 1) begin : g_addr
      assign req_addr  = path_i[VB-1 -: AW];
      assign hold_addr = path_r[VB-1 -: AW];
      assign clr_a     = clr_addr[AW-1:0];
    end else begin : g_root
      assign req_addr  = '0;
      assign hold_addr = '0;
      assign clr_a     = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (req_i.vld) begin
      ctl_r <= req_i;
    end else begin
      ctl_r.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.vld) begin
      path_r <= path_i;
      mask_r <= mask_i;
      res_r  <= res_i;
    end
  end

  assign c0 = ram_rdata[CW-1:0];
  assign c1 = ram_rdata[2*CW-1:CW];
  assign b  = mask_r[BIT];
  assign go_cnt  = b ? c1 : c0;
  assign alt_cnt = b ? c0 : c1;
  assign sel_cnt = path_r[BIT] ? c1 : c0;

  // An insert adds one to the child on the value's path; the pair is still in the read register.
  assign inc_pair = path_r[BIT] ? {c1 + CW'(1), c0} : {c1, c0 + CW'(1)};

  always_comb begin
    ram_addr  = clr_en ? clr_a : (commit ? hold_addr : req_addr);
    ram_wdata = clr_en ? '0 : inc_pair;
  end

  xmm_ram #(
    .DATA_W(2 * CW),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (clr_en | commit),
    .re   (req_i.vld),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    req_o  = ctl_r;
    path_o = path_r;
    mask_o = mask_r;
    res_o  = res_r;
    if (ctl_r.cmd == CMD_QUERY) begin
      if (!ctl_r.done) begin
        // Prefer the child matching the mask bit; a full one forces a result bit of one.
        if (go_cnt == CAP) begin
          res_o[BIT] = 1'b1;
          if (alt_cnt == '0) begin
            req_o.done = 1'b1;
          end else begin
            path_o[BIT] = ~b;
          end
        end else if (go_cnt == '0) begin
          req_o.done = 1'b1;
        end else begin
          path_o[BIT] = b;
        end
      end
    end else if (IS_LEAF && (sel_cnt != '0)) begin
      // The value is already a member, so the insert leaves the counts alone.
      req_o.done = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xor_masked_mex_search.sv =====
// A query's mex passes the token register and the register of each level cell, then is
// registered at the output. The block takes one item at a time and accepts no new item
// while one walks the level cells, one level cell per cycle, or while an insert writes
// its counts back.
// Reset: the mask clears at once, then a clearing pass over 2^(VALUE_BITS-1) addresses zeroes
// every level's count memory while no item is accepted.
`default_nettype none
module xor_masked_mex_search
  import xmm_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [MEX_W-1:0]   out_mex
);

  localparam int VB    = VALUE_BITS;
  localparam int CLR_W = (VB > 1) ? VB - 1 : 1;
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'((1 << (VB - 1)) - 1);

  state_t           state_r;
  state_t           state_nxt;
  logic [CLR_W-1:0] clr_cnt_r;
  logic [VB-1:0]    mask_r;
  logic             tok_vld_r;
  cmd_t             tok_cmd_r;
  logic [VB-1:0]    tok_path_r;
  logic             out_vld_r;
  logic [MEX_W-1:0] out_mex_r;
  logic [VB-1:0]    in_val;
  logic             accept;
  logic             clr_en;
  logic             commit;
  cmd_t             in_cmd_e;

  ctl_t          chain_ctl  [VB+1];
  logic [VB-1:0] chain_path [VB+1];
  logic [VB-1:0] chain_mask [VB+1];
  logic [VB-1:0] chain_res  [VB+1];

  assign in_val   = VB'(in_value);
  assign in_cmd_e = cmd_t'(in_cmd);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (chain_ctl[VB].vld) begin
          if (chain_ctl[VB].cmd == CMD_INSERT && !chain_ctl[VB].done) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // A query waits while an earlier mex is still held; inserts need no result slot.
  always_comb begin
    in_stall = 1'b1;
    clr_en   = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_CLEAR:  clr_en   = 1'b1;
      ST_IDLE:   in_stall = (in_cmd_e == CMD_QUERY) && out_vld_r && out_stall;
      ST_WALK:   in_stall = 1'b1;
      ST_COMMIT: commit   = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      mask_r    <= '0;
      tok_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tok_vld_r <= accept;
      if (clr_en) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      end
      if (accept && in_cmd_e == CMD_QUERY) begin
        mask_r <= mask_r ^ in_val;
      end
      if (chain_ctl[VB].vld && chain_ctl[VB].cmd == CMD_QUERY) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_cmd_r  <= in_cmd_e;
      tok_path_r <= (in_cmd_e == CMD_INSERT) ? in_val : '0;
    end
    if (chain_ctl[VB].vld && chain_ctl[VB].cmd == CMD_QUERY) begin
      out_mex_r <= MEX_W'(chain_res[VB]);
    end
  end

  always_comb begin
    chain_ctl[0].vld  = tok_vld_r;
    chain_ctl[0].cmd  = tok_cmd_r;
    chain_ctl[0].done = 1'b0;
    chain_path[0]     = tok_path_r;
    chain_mask[0]     = mask_r;
    chain_res[0]      = '0;
  end

  generate
    for (genvar g = 1; g <= VB; g++) begin : g_level
      xmm_cell #(
        .VB   (VB),
        .LEVEL(g),
        .CLR_W(CLR_W)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_en  (clr_en),
        .clr_addr(clr_cnt_r),
        .commit  (commit),
        .req_i   (chain_ctl[g-1]),
        .path_i  (chain_path[g-1]),
        .mask_i  (chain_mask[g-1]),
        .res_i   (chain_res[g-1]),
        .req_o   (chain_ctl[g]),
        .path_o  (chain_path[g]),
        .mask_o  (chain_mask[g]),
        .res_o   (chain_res[g])
      );
    end
  endgenerate

  assign out_valid = out_vld_r;
  assign out_mex   = out_mex_r;

endmodule
`default_nettype wire

// ===== verif/tb_xor_masked_mex_search.sv =====
// Self-checking testbench for the XOR-masked MEX search block, with its own tree-count predictor.
`default_nettype none
module tb_xor_masked_mex_search;
  import xmm_pkg::*;

  localparam int VB         = VALUE_BITS_DEF;
  localparam int LEAVES     = 1 << VB;
  localparam int N_ITEMS    = 1850;
  localparam int IDLE_PCT   = 27;
  localparam int PRESS_AT   = 30;
  localparam int PRESS_LEN  = 400;
  // The watchdog limit also covers the quiet clearing pass after reset.
  localparam int WATCHDOG   = 4 * (1 << (VB - 1)) + 60000;
  localparam int TAIL_WAIT  = 3 * (VB + 3);

  typedef struct {
    cmd_t                 cmd;
    logic [VALUE_W-1:0]   value;
  } op_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_cmd = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [MEX_W-1:0]   out_mex;

  op_item_t           item_backlog[$];
  logic [MEX_W-1:0]   mex_due[$];
  logic [MEX_W-1:0]   mex_want;
  op_item_t           nxt_item;

  // Predictor state: distinct-member counts per node of a heap-indexed tree.
  int unsigned        node_cnt[0:2*LEAVES-1];
  logic [VB-1:0]      mask_now = '0;

  int                 n_errors = 0;
  int                 n_sent = 0;
  int                 n_results = 0;
  int                 quiet_cycles = 0;
  int                 hold_left = 0;
  bit                 pressed = 1'b0;
  logic [VALUE_W-1:0] gen_mask = '0;

  // A stretch of items during which neither side idles.
  wire calm = (n_sent >= 800) && (n_sent < 1100);

  xor_masked_mex_search #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mex  (out_mex)
  );

  always #4 clk = ~clk;

  function automatic void count_insert(logic [VB-1:0] v);
    int unsigned node;
    node = LEAVES + v;
    if (node_cnt[node] != 0) return;
    while (node >= 1) begin
      node_cnt[node] = node_cnt[node] + 1;
      node = node >> 1;
    end
  endfunction

  // Walks from the top bit, keeping the result bit clear unless that side is full.
  function automatic logic [MEX_W-1:0] mex_lookup(logic [VB-1:0] m);
    int unsigned node;
    int unsigned go;
    int unsigned alt;
    int unsigned cap;
    logic [VB-1:0] res;
    node = 1;
    res = '0;
    for (int i = VB - 1; i >= 0; i--) begin
      go = (node << 1) | m[i];
      cap = 1 << i;
      if (node_cnt[go] == cap) begin
        alt = (node << 1) | (m[i] ^ 1'b1);
        res[i] = 1'b1;
        if (node_cnt[alt] == 0) return MEX_W'(res);
        node = alt;
      end else begin
        if (node_cnt[go] == 0) return MEX_W'(res);
        node = go;
      end
    end
    return MEX_W'(res);
  endfunction

  task automatic report_mismatch(string what, logic [MEX_W-1:0] got, logic [MEX_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  task automatic queue_insert(logic [VALUE_W-1:0] v);
    op_item_t it;
    it.cmd = CMD_INSERT;
    it.value = v;
    item_backlog.push_back(it);
  endtask

  task automatic queue_query(logic [VALUE_W-1:0] operand);
    op_item_t it;
    it.cmd = CMD_QUERY;
    it.value = operand;
    item_backlog.push_back(it);
    gen_mask = gen_mask ^ operand;
  endtask

  // Chooses the operand so that the running mask becomes the given target.
  task automatic aim_at(logic [VALUE_W-1:0] target);
    queue_query(gen_mask ^ target);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n_sent = n_sent + 1;
        if (cmd_t'(in_cmd) == CMD_QUERY) begin
          mask_now = mask_now ^ VB'(in_value);
          mex_due.push_back(mex_lookup(mask_now));
        end else begin
          count_insert(VB'(in_value));
        end
      end
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt_item = item_backlog.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt_item.cmd;
          in_value <= nxt_item.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mex_due.size() == 0) begin
          report_mismatch("mex with no query outstanding", out_mex, '0);
        end else begin
          mex_want = mex_due.pop_front();
          if (out_mex !== mex_want) report_mismatch("mex", out_mex, mex_want);
        end
        n_results++;
      end
      // One long hold-off, so that the block fills and stalls its input.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!pressed && n_results == PRESS_AT) begin
        pressed <= 1'b1;
        hold_left <= PRESS_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] home;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] target;
    int k;
    int span;
    int start;
    int cnt;
    int nq;
    int pick;

    // Empty set, then a member that lands on zero under the mask.
    queue_query(16'h0000);
    queue_query(16'hFFFF);
    queue_insert(16'hFFFF);
    queue_query(16'h0000);
    queue_insert(16'hFFFF);
    queue_query(16'h0000);
    queue_insert(16'hFFFE);
    queue_query(16'h0000);
    queue_query(16'hFFFF);
    // A full aligned block of four forces a step around a full subtree.
    queue_insert(16'h0000);
    queue_insert(16'h0001);
    queue_insert(16'h0002);
    queue_insert(16'h0003);
    queue_query(16'h0000);
    queue_query(16'h0003);
    queue_insert(16'h0005);
    queue_query(16'h0004);
    queue_query(16'h8000);
    queue_insert(16'h8000);
    queue_query(16'h0000);
    queue_insert(16'h7FFF);
    queue_query(16'h7FFF);
    aim_at(16'h0000);
    queue_insert(16'h0004);
    aim_at(16'h0000);

    // Clustered inserts build dense and full subtrees; queries aim the mask into them.
    home = {6'($urandom_range(0, 63)), 10'b0};
    while (item_backlog.size() < N_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(2, 6);
        span = 1 << k;
        if ($urandom_range(1) == 0) base = home | (16'($urandom_range(0, 1023)) & ~16'(span - 1));
        else base = 16'($urandom) & ~16'(span - 1);
        start = $urandom_range(0, span - 1);
        cnt = $urandom_range(1, span);
        for (int j = 0; j < cnt; j++) begin
          if ($urandom_range(9) != 0) queue_insert(base | 16'((start + j) & (span - 1)));
        end
        if ($urandom_range(9) == 0) queue_insert(base);
        nq = $urandom_range(1, 3);
        for (int q = 0; q < nq; q++) begin
          pick = $urandom_range(9);
          if (pick < 6) target = base | 16'($urandom_range(0, span - 1));
          else if (pick < 8) target = home | 16'($urandom_range(0, 1023));
          else if (pick == 8) target = 16'($urandom);
          else target = base ^ (16'h1 << $urandom_range(0, 15));
          aim_at(target);
        end
      end else if ($urandom_range(1) == 0) begin
        queue_insert(16'($urandom));
      end else begin
        queue_query(16'($urandom));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (item_backlog.size() != 0 || in_valid || mex_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/xmm_pkg.sv
rtl/xmm_ram.sv
rtl/xmm_cell.sv
rtl/xor_masked_mex_search.sv
verif/tb_xor_masked_mex_search.sv
